### src/assert_macros.svh
// Assertion macros used by the decoder core RTL.
// Concurrent checks are compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge out of reset.
`define UTF8D_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("utf8d assertion failed");

// Condition must never be true out of reset.
`define UTF8D_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("utf8d forbidden condition seen");

`else

`define UTF8D_ASSERT(lbl, clk, rst_n, prop)
`define UTF8D_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

### src/utf8d_pkg.sv
// Shared types and constants of the UTF-8 byte stream decoder.
// No dependencies; used by the interfaces and every decoder module.
`timescale 1ns / 1ps
`default_nettype none

package utf8d_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 31;
  localparam int unsigned TrailW = 3;

  localparam logic [ByteW-1:0] ContMask    = 8'hC0;
  localparam logic [ByteW-1:0] ContTag     = 8'h80;
  localparam logic [ByteW-1:0] TrailBits   = 8'h3F;
  localparam logic [ByteW-1:0] Lead2Bits   = 8'h1F;
  localparam logic [ByteW-1:0] Lead3Bits   = 8'h0F;
  localparam logic [ByteW-1:0] Lead4Bits   = 8'h07;
  localparam logic [ByteW-1:0] Lead5Bits   = 8'h03;
  localparam logic [ByteW-1:0] Lead6Bits   = 8'h01;

  localparam logic [TrailW-1:0] MaxTrails  = 3'd5;

  // Input register contents handed to the decode stage.
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
  } byte_stage_t;

endpackage

`default_nettype wire

### src/utf8d_stream_if.sv
// Valid/ready channel interfaces of the decoder: byte input and code point output.
// Depends on utf8d_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface utf8d_byte_if;
  logic                           valid;
  logic                           ready;
  logic [utf8d_pkg::ByteW-1:0]    data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface utf8d_cp_if;
  logic                           valid;
  logic                           ready;
  logic [utf8d_pkg::CpW-1:0]      code_point;
  logic                           stray_byte;

  modport source (output valid, output code_point, output stray_byte, input ready);
  modport sink   (input valid, input code_point, input stray_byte, output ready);
endinterface

`default_nettype wire

### src/utf8d_in_reg.sv
// Input register of the decoder: captures one byte item per cycle while free (empty, or its held item moves on).
// Depends on utf8d_pkg and utf8d_byte_if.
`timescale 1ns / 1ps
`default_nettype none

module utf8d_in_reg (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  utf8d_byte_if.sink                  byte_i,
  input  wire logic                   advance_i,
  output utf8d_pkg::byte_stage_t      stage_o
);

  logic                          valid_q, valid_d;
  logic [utf8d_pkg::ByteW-1:0]   data_q;
  logic                          take;

  // Free when empty or when the held item moves on this cycle.
  assign byte_i.ready = !valid_q || advance_i;
  assign take         = byte_i.valid && byte_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= byte_i.data_byte;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.data  = data_q;

endmodule

`default_nettype wire

### src/utf8d_core.sv
// Decode stage: sequence state, shift-accumulate and the result register.
// Depends on utf8d_pkg, utf8d_cp_if and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module utf8d_core (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire utf8d_pkg::byte_stage_t stage_i,
  output logic                        advance_o,
  utf8d_cp_if.source                  cp_o
);

  logic [utf8d_pkg::CpW-1:0]     acc_q, acc_d;
  logic [utf8d_pkg::TrailW-1:0]  trails_q, trails_d;
  logic                          out_valid_q, out_valid_d;
  logic [utf8d_pkg::CpW-1:0]     cp_q, cp_d;
  logic                          stray_q, stray_d;

  logic [utf8d_pkg::ByteW-1:0]   data;
  logic                          is_cont;
  logic                          emit;
  logic [utf8d_pkg::CpW-1:0]     shifted;
  logic                          slot_free;

  assign data      = stage_i.data;
  assign is_cont   = (data & utf8d_pkg::ContMask) == utf8d_pkg::ContTag;
  assign shifted   = {acc_q[utf8d_pkg::CpW-7:0], data[5:0]};
  assign slot_free = !out_valid_q || cp_o.ready;
  assign advance_o = stage_i.valid && slot_free;

  always_comb begin
    acc_d    = acc_q;
    trails_d = trails_q;
    emit     = 1'b0;
    cp_d     = '0;
    stray_d  = 1'b0;
    if (data == '0) begin
      // End of string: clear, also mid-sequence.
      acc_d    = '0;
      trails_d = '0;
    end else if (trails_q != '0 && is_cont) begin
      trails_d = trails_q - 3'd1;
      if (trails_d == '0) begin
        emit  = 1'b1;
        cp_d  = shifted;
        acc_d = '0;
      end else begin
        acc_d = shifted;
      end
    end else begin
      // Idle, or a broken sequence: drop it and decode the byte afresh.
      acc_d    = '0;
      trails_d = '0;
      if (data inside {[8'h00:8'h7F]}) begin
        emit = 1'b1;
        cp_d = {{(utf8d_pkg::CpW-utf8d_pkg::ByteW){1'b0}}, data};
      end else if (data inside {[8'h80:8'hBF]}) begin
        emit    = 1'b1;
        stray_d = 1'b1;
        cp_d    = {{(utf8d_pkg::CpW-utf8d_pkg::ByteW){1'b0}}, data};
      end else if (data inside {[8'hC0:8'hDF]}) begin
        acc_d    = {{(utf8d_pkg::CpW-utf8d_pkg::ByteW){1'b0}}, data & utf8d_pkg::Lead2Bits};
        trails_d = 3'd1;
      end else if (data inside {[8'hE0:8'hEF]}) begin
        acc_d    = {{(utf8d_pkg::CpW-utf8d_pkg::ByteW){1'b0}}, data & utf8d_pkg::Lead3Bits};
        trails_d = 3'd2;
      end else if (data inside {[8'hF0:8'hF7]}) begin
        acc_d    = {{(utf8d_pkg::CpW-utf8d_pkg::ByteW){1'b0}}, data & utf8d_pkg::Lead4Bits};
        trails_d = 3'd3;
      end else if (data inside {[8'hF8:8'hFB]}) begin
        acc_d    = {{(utf8d_pkg::CpW-utf8d_pkg::ByteW){1'b0}}, data & utf8d_pkg::Lead5Bits};
        trails_d = 3'd4;
      end else begin
        acc_d    = {{(utf8d_pkg::CpW-utf8d_pkg::ByteW){1'b0}}, data & utf8d_pkg::Lead6Bits};
        trails_d = utf8d_pkg::MaxTrails;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance_o) begin
      out_valid_d = emit;
    end else if (cp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      trails_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance_o) begin
        acc_q    <= acc_d;
        trails_q <= trails_d;
      end
    end
  end

  // Result payload: load only when a new item lands in the slot.
  always_ff @(posedge clk_i) begin
    if (advance_o && emit) begin
      cp_q    <= cp_d;
      stray_q <= stray_d;
    end
  end

  assign cp_o.valid      = out_valid_q;
  assign cp_o.code_point = cp_q;
  assign cp_o.stray_byte = stray_q;

  `UTF8D_NEVER(trails_in_range_a, clk_i, rst_ni, trails_q > utf8d_pkg::MaxTrails)
  `UTF8D_ASSERT(idle_acc_clear_a, clk_i, rst_ni, trails_q == '0 |-> acc_q == '0)
  `UTF8D_ASSERT(zero_byte_clears_a, clk_i, rst_ni,
                advance_o && data == '0 |=> trails_q == '0 && acc_q == '0)
  `UTF8D_ASSERT(trail_counts_down_a, clk_i, rst_ni,
                advance_o && data != '0 && trails_q != '0 && is_cont
                |=> trails_q == $past(trails_q) - 3'd1)
  `UTF8D_ASSERT(stray_is_cont_a, clk_i, rst_ni,
                out_valid_q && stray_q
                |-> cp_q[utf8d_pkg::CpW-1:8] == '0 && cp_q[7:6] == 2'b10)

endmodule

`default_nettype wire

### src/utf8_byte_stream_decoder_top.sv
// The result register loads when a byte item in the input register advances into the decode
// stage and completes a character; bytes that complete no character yield nothing.
// Throughput: one byte item per cycle unless a stalled result slot holds the flow.
// A stalled result slot holds the input register; one more byte still waits there.
// Reset (rst_ni low, asynchronous): empties both registers and clears the accumulator
// and the trail count, so the decoder starts idle.
`timescale 1ns / 1ps
`default_nettype none

module utf8_byte_stream_decoder_top (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  utf8d_byte_if.sink     byte_i,
  utf8d_cp_if.source     cp_o
);

  utf8d_pkg::byte_stage_t stage;
  logic                   advance;

  utf8d_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (byte_i),
    .advance_i (advance),
    .stage_o   (stage)
  );

  utf8d_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .stage_i   (stage),
    .advance_o (advance),
    .cp_o      (cp_o)
  );

endmodule

`default_nettype wire
